>>> hdl/qat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_pkg
// Shared byte codes, quote state type and result word for the argument
// tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } t_quote;

    typedef struct packed {
        logic   inside_word;
        t_quote quote_mode;
        logic   escape_pending;
        logic   seen_word;
    } t_state;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       word_end;
        logic       string_end;
    } t_result;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

>>> hdl/qat_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_core
// Tokenizer state and per-byte decode: word, quote and escape tracking.
// ----------------------------------------------------------------------------
module qat_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [7:0]        i_char,
    output qat_pkg::t_result  o_result
);

    qat_pkg::t_state r_state;
    qat_pkg::t_state n_state;
    qat_pkg::t_quote w_qm;
    logic            w_quote_open;

    always_comb begin
        n_state      = r_state;
        o_result     = '0;
        w_qm         = r_state.quote_mode;
        w_quote_open = 1'b0;
        if (i_char == qat_pkg::CH_NUL) begin
            // end of string, a string with no word reports one empty word
            o_result.string_end = 1'b1;
            o_result.word_end   = r_state.inside_word || !r_state.seen_word;
            n_state.inside_word    = 1'b0;
            n_state.quote_mode     = qat_pkg::QM_NONE;
            n_state.escape_pending = 1'b0;
            n_state.seen_word      = 1'b0;
        end else if (r_state.escape_pending) begin
            n_state.escape_pending = 1'b0;
            o_result.out_char      = i_char;
            o_result.char_valid    = 1'b1;
        end else if (!r_state.inside_word && qat_pkg::is_sep(i_char)) begin
            // whitespace between words
        end else begin
            if (!r_state.inside_word) begin
                n_state.inside_word = 1'b1;
                n_state.seen_word   = 1'b1;
                w_qm                = qat_pkg::QM_NONE;
            end
            n_state.quote_mode = w_qm;
            w_quote_open = (w_qm == qat_pkg::QM_SINGLE) || (w_qm == qat_pkg::QM_DOUBLE);
            if (qat_pkg::is_sep(i_char) && !w_quote_open) begin
                o_result.word_end   = 1'b1;
                n_state.inside_word = 1'b0;
            end else begin
                case (i_char)
                    qat_pkg::CH_BSLASH: begin
                        n_state.escape_pending = 1'b1;
                    end
                    qat_pkg::CH_DQUOTE: begin
                        if (w_qm == qat_pkg::QM_SINGLE) begin
                            o_result.out_char   = i_char;
                            o_result.char_valid = 1'b1;
                        end else if (w_qm == qat_pkg::QM_DOUBLE) begin
                            n_state.quote_mode = qat_pkg::QM_NONE;
                        end else begin
                            n_state.quote_mode = qat_pkg::QM_DOUBLE;
                        end
                    end
                    qat_pkg::CH_SQUOTE: begin
                        if (w_qm == qat_pkg::QM_DOUBLE) begin
                            o_result.out_char   = i_char;
                            o_result.char_valid = 1'b1;
                        end else if (w_qm == qat_pkg::QM_SINGLE) begin
                            n_state.quote_mode = qat_pkg::QM_NONE;
                        end else begin
                            n_state.quote_mode = qat_pkg::QM_SINGLE;
                        end
                    end
                    default: begin
                        o_result.out_char   = i_char;
                        o_result.char_valid = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.inside_word    <= 1'b0;
            r_state.quote_mode     <= qat_pkg::QM_NONE;
            r_state.escape_pending <= 1'b0;
            r_state.seen_word      <= 1'b0;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/quoted_argument_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a zero-terminated command string, one byte per transfer, into words
// with shell-style quoting and backslash escapes.
// ----------------------------------------------------------------------------
// pipeline: the input register loads at the handshake edge, the result register
//   once the output stage can take it (empty or i_m_tready)
// throughput: one byte per cycle while the output is not stalled; the state
//   update in qat_core is the only recurrence
// reset: synchronous active low, clears tokenizer state and both valid flags
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic [1:0] o_m_tuser,   // [0] char_valid, [1] word_end
    output logic       o_m_tlast    // string_end
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_out_valid;
    qat_pkg::t_result r_out;
    qat_pkg::t_result w_result;
    logic             w_out_load;
    logic             w_adv;

    assign w_out_load = !r_out_valid || i_m_tready;
    assign w_adv      = r_in_valid && w_out_load;
    assign o_s_tready = !r_in_valid || w_out_load;

    qat_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_char   (r_in_char),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.out_char;
    assign o_m_tuser  = {r_out.word_end, r_out.char_valid};
    assign o_m_tlast  = r_out.string_end;

endmodule

>>> hdl/qat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qat_checker
// Port-level checks on the tokenizer result stream.
// ----------------------------------------------------------------------------
module qat_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser,
    input logic       o_m_tlast
);

    // a literal byte never closes a word
    a_char_not_word_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("char_valid and word_end both set");

    // no byte means a zero data field
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> (o_m_tdata == 8'h00))
        else $error("data nonzero without char_valid");

    // the terminating word carries no literal byte
    a_last_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> !o_m_tuser[0])
        else $error("string_end with char_valid");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast)))
        else $error("stalled word changed");

endmodule

bind quoted_argument_tokenizer qat_checker u_qat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
